// ===== sv/fsnp_pkg.sv =====
package fsnp_pkg;

    // Argument width and digit store depth
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_W   = MAX_DIGITS * DIGIT_W;
    localparam int HEX_DIGITS = ((VALUE_BITS + 3) / 4 < MAX_DIGITS) ?
                                (VALUE_BITS + 3) / 4 : MAX_DIGITS;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int CNT_W      = 16;
    localparam int ARG_W      = 64;

    // Character codes
    localparam logic [7:0] CHR_NUL  = 8'h00;
    localparam logic [7:0] CHR_PCT  = 8'h25;
    localparam logic [7:0] CHR_D    = 8'h64;
    localparam logic [7:0] CHR_X_LO = 8'h78;
    localparam logic [7:0] CHR_X_UP = 8'h58;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_A    = 8'h61;

    localparam logic [CNT_W-1:0] MAX_CHARS_RST = 16'hFFFF;

    typedef logic [DIGITS_W-1:0] digits_t;

    // Map one digit to lowercase ASCII
    function automatic logic [7:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [7:0] w;
        w = {4'b0000, d};
        if (d < 4'd10)
        begin
            to_ascii = CHR_ZERO + w;
        end
        else
        begin
            to_ascii = CHR_A + w - 8'd10;
        end
    endfunction

    // Split the argument into hex nibbles, least significant first
    function automatic digits_t hex_digits(input logic [VALUE_BITS-1:0] v);
        logic [HEX_DIGITS*4-1:0] ext;
        digits_t d;
        ext = (HEX_DIGITS*4)'(v);
        d   = '0;
        for (int i = 0; i < HEX_DIGITS; i++)
        begin
            d[i*DIGIT_W +: DIGIT_W] = ext[i*4 +: 4];
        end
        hex_digits = d;
    endfunction

endpackage

// ===== sv/fsnp_if.sv =====
interface fsnp_in_if;
    logic                        valid;
    logic                        ready;
    logic [7:0]                  fmt_byte;
    logic [fsnp_pkg::ARG_W-1:0]  arg_value;
    logic                        restart;

    modport source (output valid, output fmt_byte, output arg_value, output restart,
                    input ready);
    modport sink   (input valid, input fmt_byte, input arg_value, input restart,
                    output ready);
endinterface

interface fsnp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ===== sv/fsnp_bcd_step.sv =====
// One shift-and-add-3 step of binary to BCD conversion over the digit store.
// Carry out of the top digit drops, so the store keeps the low digits only.
module fsnp_bcd_step
(
    input  fsnp_pkg::digits_t digits_in,
    input  logic              bit_in,
    output fsnp_pkg::digits_t digits_out
);

    fsnp_pkg::digits_t adj;

    // Add 3 to every digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < fsnp_pkg::MAX_DIGITS; i++)
        begin
            if (digits_in[i*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W] >= 4'd5)
            begin
                adj[i*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W] =
                    digits_in[i*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                adj[i*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W] =
                    digits_in[i*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W];
            end
        end
    end

    // Shift in the next argument bit
    assign digits_out = {adj[fsnp_pkg::DIGITS_W-2:0], bit_in};

endmodule

// ===== sv/format_string_number_printer.sv =====
// Channel  | Dir | Payload                          | Handshake
// ---------+-----+----------------------------------+-------------
// in_ch    | in  | fmt_byte, arg_value, restart     | valid/ready
// out_ch   | out | out_char, last                   | valid/ready
// cfg      | in  | cfg_wr_data (max_chars)          | cfg_wr_en
//
// A plain byte or "%%" passes through the put state to the output register.
// "%d" runs the shared BCD shift/add-3 unit over every argument bit, then skips
// leading zeros, then emits the digits most significant first; "%x" skips the
// BCD pass. The block takes one request at a time: in_ch.ready is low
// while a request is in work. A stalled out_ch holds the digit sequencer.
// Reset clears the sequencer, the count and the pending flag, and sets max_chars to 65535.
module format_string_number_printer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [fsnp_pkg::CNT_W-1:0]  cfg_wr_data,
    fsnp_in_if.sink                     in_ch,
    fsnp_out_if.source                  out_ch
);

    typedef enum logic [2:0] {S_IDLE, S_PUT, S_CONV, S_SCAN, S_EMIT} state_t;

    state_t                              state_reg;
    logic                                pend_reg;
    logic [fsnp_pkg::CNT_W-1:0]          cnt_reg;
    logic [fsnp_pkg::CNT_W-1:0]          max_reg;
    logic [fsnp_pkg::IDX_W-1:0]          idx_reg;
    logic [fsnp_pkg::BIT_CNT_W-1:0]      bit_cnt_reg;
    logic [7:0]                          char_reg;
    logic                                out_valid_reg;
    logic [7:0]                          out_char_reg;
    logic                                out_last_reg;
    fsnp_pkg::digits_t                   digits_reg;
    fsnp_pkg::digits_t                   digits_next;
    logic [fsnp_pkg::VALUE_BITS-1:0]     value_reg;

    logic                                accept;
    logic                                slot_free;
    logic                                at_limit;
    logic                                load_out;
    logic [fsnp_pkg::CNT_W-1:0]          cnt_eff;
    logic                                pend_eff;
    logic [fsnp_pkg::DIGIT_W-1:0]        cur_digit;
    logic                                emit_last;

    assign accept    = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign at_limit  = cnt_reg >= max_reg;
    assign cur_digit = digits_reg[idx_reg*fsnp_pkg::DIGIT_W +: fsnp_pkg::DIGIT_W];
    assign emit_last = (idx_reg == '0) || (cnt_reg + 16'd1 == max_reg);
    assign load_out  = ((state_reg == S_PUT) || (state_reg == S_EMIT))
                       && !at_limit && slot_free;
    assign cnt_eff   = in_ch.restart ? '0 : cnt_reg;
    assign pend_eff  = in_ch.restart ? 1'b0 : pend_reg;

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_char_reg;
    assign out_ch.last     = out_last_reg;

    // Shared BCD conversion step
    fsnp_bcd_step u_bcd_step
    (
        .digits_in  (digits_reg),
        .bit_in     (value_reg[fsnp_pkg::VALUE_BITS-1]),
        .digits_out (digits_next)
    );

    // Sequencer, count, pending flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            max_reg       <= fsnp_pkg::MAX_CHARS_RST;
            idx_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end

            // Load a new character, or drop the output request once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_reg + 16'd1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg  <= cnt_eff;
                        pend_reg <= 1'b0;
                        if (in_ch.fmt_byte == fsnp_pkg::CHR_NUL)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (pend_eff)
                        begin
                            if (in_ch.fmt_byte == fsnp_pkg::CHR_PCT)
                            begin
                                state_reg <= S_PUT;
                            end
                            else if (in_ch.fmt_byte == fsnp_pkg::CHR_D)
                            begin
                                bit_cnt_reg <= '0;
                                state_reg   <= S_CONV;
                            end
                            else if (in_ch.fmt_byte == fsnp_pkg::CHR_X_LO ||
                                     in_ch.fmt_byte == fsnp_pkg::CHR_X_UP)
                            begin
                                idx_reg   <= fsnp_pkg::IDX_W'(fsnp_pkg::MAX_DIGITS - 1);
                                state_reg <= S_SCAN;
                            end
                        end
                        else if (in_ch.fmt_byte == fsnp_pkg::CHR_PCT)
                        begin
                            pend_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_PUT;
                        end
                    end
                end
                S_PUT:
                begin
                    if (at_limit || slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == fsnp_pkg::BIT_CNT_W'(fsnp_pkg::VALUE_BITS - 1))
                    begin
                        idx_reg   <= fsnp_pkg::IDX_W'(fsnp_pkg::MAX_DIGITS - 1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Skip leading zeros, keep at least one digit
                    if (idx_reg == '0 || cur_digit != '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (at_limit)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: character, digit store, shifting argument, output data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg   <= (in_ch.fmt_byte == fsnp_pkg::CHR_PCT) ? fsnp_pkg::CHR_PCT
                                                                 : in_ch.fmt_byte;
            value_reg  <= in_ch.arg_value[fsnp_pkg::VALUE_BITS-1:0];
            if (in_ch.fmt_byte == fsnp_pkg::CHR_D)
            begin
                digits_reg <= '0;
            end
            else
            begin
                digits_reg <= fsnp_pkg::hex_digits(
                                  in_ch.arg_value[fsnp_pkg::VALUE_BITS-1:0]);
            end
        end
        else if (state_reg == S_CONV)
        begin
            digits_reg <= digits_next;
            value_reg  <= {value_reg[fsnp_pkg::VALUE_BITS-2:0], 1'b0};
        end

        if (load_out)
        begin
            if (state_reg == S_PUT)
            begin
                out_char_reg <= char_reg;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_char_reg <= fsnp_pkg::to_ascii(cur_digit);
                out_last_reg <= emit_last;
            end
        end
    end

    // Output requests start only from the put or emit states
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUT || state_reg == S_EMIT))
        else $error("output request raised outside put/emit");

    // Each loaded character advances the count by one
    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> cnt_reg == $past(cnt_reg) + 16'd1)
        else $error("character count did not advance");

    // The digit pointer stays inside the store while digits are read
    a_idx_rng: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_EMIT) |->
            idx_reg <= fsnp_pkg::IDX_W'(fsnp_pkg::MAX_DIGITS - 1))
        else $error("digit index out of range");

    // No new request is taken while a conversion is running
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> !in_ch.ready)
        else $error("input ready during conversion");

endmodule

// ===== tb/sv/format_char_checker.sv =====
module format_char_checker
    import fsnp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    fsnp_in_if               in_ch,
    fsnp_out_if              out_ch,
    output int               mismatches,
    output int               chars_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_rec_t;

    // Characters still owed by the block, oldest first
    char_rec_t        due_chars[$];

    logic [CNT_W-1:0] char_limit = MAX_CHARS_RST;
    logic [CNT_W-1:0] chars_out  = '0;
    logic             pct_armed  = 1'b0;
    int               miss_count = 0;
    int               due_count  = 0;

    assign mismatches = miss_count;
    assign chars_due  = due_count;

    // Queue one character unless the string has used up its limit
    function automatic void put_char(input logic [7:0] c);
        if (chars_out >= char_limit)
        begin
            return;
        end
        due_chars.push_back('{ch: c, last: 1'b0});
        chars_out = chars_out + 1'b1;
    endfunction

    // Queue the digits of v in the given radix, most significant first
    function automatic void put_number(input logic [63:0] v, input logic [63:0] radix);
        logic [3:0]  digs [MAX_DIGITS];
        logic [63:0] rest;
        logic [7:0]  c;
        int          cnt;
        rest = v;
        cnt  = 0;
        do
        begin
            digs[cnt] = 4'(rest % radix);
            rest      = rest / radix;
            cnt++;
        end
        while (rest != 0 && cnt < MAX_DIGITS);
        for (int i = cnt - 1; i >= 0; i--)
        begin
            c = {4'h0, digs[i]};
            c = (digs[i] < 4'd10) ? CHR_ZERO + c : CHR_A + c - 8'd10;
            put_char(c);
        end
    endfunction

    // Work out the characters one format byte produces
    function automatic void render_byte(input logic [7:0] b, input logic [ARG_W-1:0] a,
                                        input logic rs);
        int          base_n;
        logic [63:0] v;
        char_rec_t   tail;
        base_n = due_chars.size();
        v      = 64'(a[VALUE_BITS-1:0]);
        if (rs)
        begin
            chars_out = '0;
            pct_armed = 1'b0;
        end
        if (b == CHR_NUL)
        begin
            pct_armed = 1'b0;
        end
        else if (pct_armed)
        begin
            pct_armed = 1'b0;
            if (b == CHR_PCT)
            begin
                put_char(CHR_PCT);
            end
            else if (b == CHR_D)
            begin
                put_number(v, 64'd10);
            end
            else if (b == CHR_X_LO || b == CHR_X_UP)
            begin
                put_number(v, 64'd16);
            end
        end
        else if (b == CHR_PCT)
        begin
            pct_armed = 1'b1;
        end
        else
        begin
            put_char(b);
        end
        // Mark the final character of this request
        if (due_chars.size() > base_n)
        begin
            tail      = due_chars[due_chars.size() - 1];
            tail.last = 1'b1;
            due_chars[due_chars.size() - 1] = tail;
        end
    endfunction

    // Compare one delivered character with the oldest one owed
    task automatic check_char(input logic [7:0] c, input logic l);
        char_rec_t want;
        if (due_chars.size() == 0)
        begin
            $display("%0t: unexpected char: expected none, actual char %h last %b",
                     $time, c, l);
            miss_count++;
        end
        else
        begin
            want = due_chars.pop_front();
            if (want.ch !== c || want.last !== l)
            begin
                $display("%0t: char mismatch: expected char %h last %b, actual char %h last %b",
                         $time, want.ch, want.last, c, l);
                miss_count++;
            end
        end
    endtask

    // Track config, predict on each request, check each character
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit = MAX_CHARS_RST;
            chars_out  = '0;
            pct_armed  = 1'b0;
            due_chars.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                char_limit = cfg_wr_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                render_byte(in_ch.fmt_byte, in_ch.arg_value, in_ch.restart);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                check_char(out_ch.out_char, out_ch.last);
            end
        end
        due_count = due_chars.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsnp_pkg::*;

    localparam int SETTLE_CYCLES = 160;
    localparam int TAIL_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DIRECTED_REQS = 25;
    localparam int CHUNK_REQS    = 68;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             take_out    = 1'b0;

    int               mismatches;
    int               chars_due;
    int               reqs_sent     = 0;
    int               quiet_cycles  = 0;
    int               send_idle_pct = 27;
    int               recv_idle_pct = 77;
    logic             new_string    = 1'b0;

    fsnp_in_if  in_bus();
    fsnp_out_if out_bus();

    format_string_number_printer u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_bus),
        .out_ch      (out_bus)
    );

    format_char_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_bus),
        .out_ch      (out_bus),
        .mismatches  (mismatches),
        .chars_due   (chars_due)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the character stream at random
    assign out_bus.ready = take_out;

    always @(negedge clk)
    begin
        take_out <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("format_string_number_printer verification failed");
            $finish;
        end
    end

    // Present one request and hold it until accepted
    task automatic put_req(input logic [7:0] b, input logic [ARG_W-1:0] a, input logic rs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.fmt_byte  <= b;
        in_bus.arg_value <= a;
        in_bus.restart   <= rs;
        do
        begin
            @(posedge clk);
        end
        while (!in_bus.ready);
        @(negedge clk);
        reqs_sent++;
    endtask

    // Drain the block, then write the character limit
    task automatic set_char_limit(input logic [CNT_W-1:0] lim);
        in_bus.valid <= 1'b0;
        @(negedge clk);
        while (chars_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Argument with a spread of magnitudes
    function automatic logic [ARG_W-1:0] rand_arg();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(1, 63);
            3: v = v >> $urandom_range(40, 63);
            4: v = {1'b1, v[62:0]};
            default: ;
        endcase
        return v;
    endfunction

    // Send a byte, opening a new string where due
    task automatic feed(input logic [7:0] b, input logic [ARG_W-1:0] a);
        logic rs;
        rs         = new_string || ($urandom_range(0, 49) == 0);
        new_string = 1'b0;
        put_req(b, a, rs);
    endtask

    // Send one random format string built from tokens
    task automatic send_format_string();
        int         n_tok;
        int         kind;
        logic [7:0] b;
        n_tok      = $urandom_range(1, 8);
        new_string = 1'b1;
        for (int t = 0; t < n_tok; t++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                do
                begin
                    b = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126))
                                                   : 8'($urandom_range(1, 255));
                end
                while (b == CHR_PCT);
                feed(b, rand_arg());
            end
            else if (kind < 75)
            begin
                feed(CHR_PCT, rand_arg());
                if (kind < 50)
                begin
                    feed(CHR_D, rand_arg());
                end
                else if (kind < 60)
                begin
                    feed(CHR_X_LO, rand_arg());
                end
                else if (kind < 67)
                begin
                    feed(CHR_X_UP, rand_arg());
                end
                else
                begin
                    feed(CHR_PCT, rand_arg());
                end
            end
            else if (kind < 82)
            begin
                // Percent followed by a selector it does not know
                do
                begin
                    b = 8'($urandom_range(1, 255));
                end
                while (b == CHR_PCT || b == CHR_D || b == CHR_X_LO || b == CHR_X_UP);
                feed(CHR_PCT, rand_arg());
                feed(b, rand_arg());
            end
            else if (kind < 87)
            begin
                feed(CHR_PCT, rand_arg());
                feed(CHR_NUL, rand_arg());
            end
            else if (kind < 92)
            begin
                feed(CHR_NUL, rand_arg());
            end
            else
            begin
                feed(8'($urandom_range(0, 255)), {$urandom, $urandom});
            end
        end
        // Leave a lone percent at the end now and then
        if ($urandom_range(0, 9) == 0)
        begin
            feed(CHR_PCT, rand_arg());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [CNT_W-1:0] limits [6];
        in_bus.valid     = 1'b0;
        in_bus.fmt_byte  = '0;
        in_bus.arg_value = '0;
        in_bus.restart   = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Plain bytes, every conversion, and the odd cases at full limit
        set_char_limit(16'hFFFF);
        put_req("A", '0, 1'b1);
        put_req(8'hFF, '1, 1'b0);
        put_req(8'h01, '0, 1'b0);
        put_req(CHR_PCT, '1, 1'b0);
        put_req(CHR_D, '0, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_D, '1, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_X_LO, '1, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_X_UP, 64'h0123_4567_89AB_CDEF, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_PCT, '1, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req("q", '1, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_NUL, '1, 1'b0);
        put_req(CHR_NUL, '0, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req("B", '0, 1'b1);

        // Limit hit in the middle of a number, then a swallowed percent
        set_char_limit(16'd5);
        put_req(CHR_PCT, '0, 1'b1);
        put_req(CHR_D, 64'h8000_0000_0000_0000, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);
        put_req(CHR_PCT, '0, 1'b0);

        // Nothing may come out with a zero limit
        set_char_limit(16'd0);
        put_req("Z", '0, 1'b1);

        // Random strings over three idle patterns and six limits
        limits = '{16'hFFFF, 16'd24, 16'd1, 16'd60, 16'd0,
                   16'($urandom_range(8, 200))};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 27 : (p == 1) ? 77 : 0;
            recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 27 : 0;
            for (int c = 0; c < 2; c++)
            begin
                set_char_limit(limits[p * 2 + c]);
                while (reqs_sent < DIRECTED_REQS + CHUNK_REQS * (p * 2 + c + 1))
                begin
                    send_format_string();
                end
            end
        end
        in_bus.valid <= 1'b0;

        // Drain and let the block settle
        while (chars_due != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && chars_due == 0)
        begin
            $display("format_string_number_printer verification clean");
        end
        else
        begin
            $display("format_string_number_printer verification failed");
        end
        $finish;
    end

endmodule
